// File: rtl/eale_pkg.sv
// eale_pkg: shared types, sizes and codes for the exec allowlist engine
// no dependencies; used by every module under rtl
package eale_pkg;

	localparam int MON_ENTRIES = 1024;
	localparam int TRK_ENTRIES = 1024;
	localparam int ALW_ENTRIES = 8192;

	localparam int MON_AW = $clog2(MON_ENTRIES);
	localparam int TRK_AW = $clog2(TRK_ENTRIES);
	localparam int ALW_AW = $clog2(ALW_ENTRIES);
	localparam int MAX_AW = (ALW_AW > MON_AW) ? ((ALW_AW > TRK_AW) ? ALW_AW : TRK_AW)
		: ((MON_AW > TRK_AW) ? MON_AW : TRK_AW);
	localparam int IDX_W = MAX_AW + 1;

	localparam int WIN_W = 40;
	localparam logic [WIN_W-1:0] WIN_RESET = 40'd30000000000;

	localparam logic FUNC_EXEC = 1'b0;
	localparam logic FUNC_ADD = 1'b1;

	localparam logic [1:0] MODE_LEARN = 2'd0;
	localparam logic [1:0] MODE_STABLE = 2'd1;
	localparam logic [1:0] MODE_ENFORCE = 2'd2;

	localparam logic REG_LEARN = 1'b0;
	localparam logic REG_GRACE = 1'b1;

	typedef enum logic [1:0] {
		K_ADD = 2'd0,
		K_NOFILE = 2'd1,
		K_FILE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [63:0] cgroup_id;
		logic [31:0] device_number;
		logic [63:0] inode_number;
		logic [63:0] now_time;
	} item_t;

	typedef struct packed {
		logic deny;
		logic monitored;
		logic [1:0] mode_after;
		logic newly_learned;
		logic table_full;
	} res_t;

	typedef struct packed {
		logic [63:0] group;
		logic [1:0] mode;
		logic [63:0] last_new;
	} trk_t;

	typedef struct packed {
		logic [63:0] group;
		logic [31:0] device;
		logic [63:0] inode;
	} alw_t;

endpackage

// File: rtl/eale_front.sv
// eale_front: accepts input beats, classifies them and holds them in a two-deep queue
// depends on eale_pkg
module eale_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic [63:0] cgroup_id,
	input  logic has_file,
	input  logic [31:0] device_number,
	input  logic [63:0] inode_number,
	input  logic [63:0] now_time,
	output logic q_valid,
	output eale_pkg::item_t q_item,
	input  logic q_pop
);

	eale_pkg::item_t slot_q [2];
	eale_pkg::item_t item_c;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;

	// classify: add command, exec without file, exec with file
	always_comb begin
		item_c.cgroup_id = cgroup_id;
		item_c.device_number = device_number;
		item_c.inode_number = inode_number;
		item_c.now_time = now_time;
		if (func == eale_pkg::FUNC_ADD) begin
			item_c.kind = eale_pkg::K_ADD;
		end else if (has_file) begin
			item_c.kind = eale_pkg::K_FILE;
		end else begin
			item_c.kind = eale_pkg::K_NOFILE;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/eale_back.sv
// eale_back: sequencer that scans the monitor, record and allowlist memories
// depends on eale_pkg; owns the three memories and the result register
module eale_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  eale_pkg::item_t q_item,
	output logic q_pop,
	input  logic [eale_pkg::WIN_W-1:0] learn_window,
	input  logic [eale_pkg::WIN_W-1:0] grace_window,
	output logic res_valid,
	output eale_pkg::res_t res,
	input  logic res_ready
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_MRD   = 11'b00000000010,
		ST_MCMP  = 11'b00000000100,
		ST_TRD   = 11'b00000001000,
		ST_TCMP  = 11'b00000010000,
		ST_DEC1  = 11'b00000100000,
		ST_DELTA = 11'b00001000000,
		ST_MODE  = 11'b00010000000,
		ST_ARD   = 11'b00100000000,
		ST_ACMP  = 11'b01000000000,
		ST_DEC2  = 11'b10000000000
	} state_t;

	state_t state_q;
	eale_pkg::item_t item_q;
	logic [eale_pkg::IDX_W-1:0] idx_q;
	logic [eale_pkg::MON_AW:0] mcnt_q;
	logic [eale_pkg::TRK_AW:0] tcnt_q;
	logic [eale_pkg::ALW_AW:0] acnt_q;
	logic m_hit_q;
	logic t_hit_q;
	logic a_hit_q;
	logic [eale_pkg::TRK_AW-1:0] t_idx_q;
	eale_pkg::trk_t trk_q;
	logic [63:0] delta_q;
	logic [1:0] md_q;
	logic res_valid_q;
	eale_pkg::res_t res_q;

	logic [63:0] mon_mem [eale_pkg::MON_ENTRIES];
	eale_pkg::trk_t trk_mem [eale_pkg::TRK_ENTRIES];
	eale_pkg::alw_t alw_mem [eale_pkg::ALW_ENTRIES];
	logic [63:0] mon_rd;
	eale_pkg::trk_t trk_rd;
	eale_pkg::alw_t alw_rd;

	logic mon_we;
	logic trk_we;
	logic alw_we;
	logic [eale_pkg::TRK_AW-1:0] trk_waddr;
	eale_pkg::trk_t trk_wdata;
	eale_pkg::alw_t alw_wdata;
	logic fin;
	eale_pkg::res_t res_c;
	logic room_m;
	logic room_t;
	logic room_a;
	logic [1:0] smode;
	logic [63:0] lim1;
	logic [63:0] lim2;
	logic [1:0] md_c;

	assign room_m = (mcnt_q != (eale_pkg::MON_AW+1)'(eale_pkg::MON_ENTRIES));
	assign room_t = (tcnt_q != (eale_pkg::TRK_AW+1)'(eale_pkg::TRK_ENTRIES));
	assign room_a = (acnt_q != (eale_pkg::ALW_AW+1)'(eale_pkg::ALW_ENTRIES));
	assign smode = t_hit_q ? trk_q.mode : eale_pkg::MODE_LEARN;
	assign q_pop = (state_q == ST_IDLE) && q_valid && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign lim1 = {24'd0, learn_window};
	assign lim2 = {23'd0, {1'b0, learn_window} + {1'b0, grace_window}};
	always_comb begin
		if (delta_q < lim1) begin
			md_c = eale_pkg::MODE_LEARN;
		end else if (delta_q < lim2) begin
			md_c = eale_pkg::MODE_STABLE;
		end else begin
			md_c = eale_pkg::MODE_ENFORCE;
		end
	end

	assign alw_wdata.group = item_q.cgroup_id;
	assign alw_wdata.device = item_q.device_number;
	assign alw_wdata.inode = item_q.inode_number;

	// decisions: result fields and memory writes
	always_comb begin
		fin = 1'b0;
		res_c = '0;
		mon_we = 1'b0;
		trk_we = 1'b0;
		alw_we = 1'b0;
		trk_waddr = t_idx_q;
		trk_wdata = trk_q;
		unique case (state_q)
			ST_DEC1: begin
				fin = 1'b1;
				case (item_q.kind)
					eale_pkg::K_ADD: begin
						res_c.monitored = m_hit_q || room_m;
						res_c.table_full = !m_hit_q && !room_m;
						res_c.mode_after = smode;
						mon_we = !m_hit_q && room_m;
					end
					eale_pkg::K_NOFILE: begin
						res_c.monitored = m_hit_q;
						res_c.mode_after = m_hit_q ? smode : eale_pkg::MODE_LEARN;
					end
					eale_pkg::K_FILE: begin
						res_c.monitored = m_hit_q;
						if (m_hit_q && !t_hit_q) begin
							// first exec of the group opens its record
							trk_we = room_t;
							res_c.table_full = !room_t;
							trk_waddr = tcnt_q[eale_pkg::TRK_AW-1:0];
							trk_wdata.group = item_q.cgroup_id;
							trk_wdata.mode = eale_pkg::MODE_LEARN;
							trk_wdata.last_new = item_q.now_time;
						end else if (m_hit_q) begin
							fin = 1'b0;
						end
					end
					default: begin
						res_c = '0;
					end
				endcase
			end
			ST_DEC2: begin
				fin = 1'b1;
				trk_we = 1'b1;
				res_c.monitored = 1'b1;
				res_c.mode_after = md_q;
				trk_wdata.mode = md_q;
				if (!a_hit_q) begin
					if (md_q == eale_pkg::MODE_ENFORCE) begin
						res_c.deny = 1'b1;
					end else if (room_a) begin
						alw_we = 1'b1;
						res_c.newly_learned = 1'b1;
						res_c.mode_after = eale_pkg::MODE_LEARN;
						trk_wdata.mode = eale_pkg::MODE_LEARN;
						trk_wdata.last_new = item_q.now_time;
					end else begin
						res_c.table_full = 1'b1;
					end
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mon_rd <= mon_mem[idx_q[eale_pkg::MON_AW-1:0]];
		if (mon_we) begin
			mon_mem[mcnt_q[eale_pkg::MON_AW-1:0]] <= item_q.cgroup_id;
		end
	end

	always_ff @(posedge clk) begin
		trk_rd <= trk_mem[idx_q[eale_pkg::TRK_AW-1:0]];
		if (trk_we) begin
			trk_mem[trk_waddr] <= trk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		alw_rd <= alw_mem[idx_q[eale_pkg::ALW_AW-1:0]];
		if (alw_we) begin
			alw_mem[acnt_q[eale_pkg::ALW_AW-1:0]] <= alw_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_TCMP && trk_rd.group == item_q.cgroup_id) begin
			trk_q <= trk_rd;
			t_idx_q <= idx_q[eale_pkg::TRK_AW-1:0];
		end
		if (state_q == ST_DELTA) begin
			delta_q <= item_q.now_time - trk_q.last_new;
		end
		if (state_q == ST_MODE) begin
			md_q <= md_c;
		end
		if (fin) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			mcnt_q <= '0;
			tcnt_q <= '0;
			acnt_q <= '0;
			m_hit_q <= 1'b0;
			t_hit_q <= 1'b0;
			a_hit_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (mon_we) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (trk_we && state_q == ST_DEC1) begin
				tcnt_q <= tcnt_q + 1'b1;
			end
			if (alw_we) begin
				acnt_q <= acnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						idx_q <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					if (idx_q == eale_pkg::IDX_W'(mcnt_q)) begin
						m_hit_q <= 1'b0;
						idx_q <= '0;
						state_q <= ST_TRD;
					end else begin
						state_q <= ST_MCMP;
					end
				end
				ST_MCMP: begin
					if (mon_rd == item_q.cgroup_id) begin
						m_hit_q <= 1'b1;
						idx_q <= '0;
						state_q <= ST_TRD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_MRD;
					end
				end
				ST_TRD: begin
					if (idx_q == eale_pkg::IDX_W'(tcnt_q)) begin
						t_hit_q <= 1'b0;
						state_q <= ST_DEC1;
					end else begin
						state_q <= ST_TCMP;
					end
				end
				ST_TCMP: begin
					if (trk_rd.group == item_q.cgroup_id) begin
						t_hit_q <= 1'b1;
						state_q <= ST_DEC1;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_TRD;
					end
				end
				ST_DEC1: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					state_q <= ST_MODE;
				end
				ST_MODE: begin
					idx_q <= '0;
					state_q <= ST_ARD;
				end
				ST_ARD: begin
					if (idx_q == eale_pkg::IDX_W'(acnt_q)) begin
						a_hit_q <= 1'b0;
						state_q <= ST_DEC2;
					end else begin
						state_q <= ST_ACMP;
					end
				end
				ST_ACMP: begin
					if (alw_rd.group == item_q.cgroup_id
						&& alw_rd.device == item_q.device_number
						&& alw_rd.inode == item_q.inode_number) begin
						a_hit_q <= 1'b1;
						state_q <= ST_DEC2;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_ARD;
					end
				end
				ST_DEC2: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/exec_allowlist_learn_enforce.sv
// exec_allowlist_learn_enforce: top level of the per-group exec allowlist engine
// depends on eale_pkg, eale_front and eale_back; holds the window registers and the apb port
//
// per-group exec allowlist with learning, stable and enforcing modes. a beat with func 1
// adds a group to the monitored set; a beat with func 0 is an exec event. every input beat
// gives exactly one result beat. the front end takes beats into a two-deep queue, so up to
// two beats are taken while the engine is busy or a result waits on out_ready. the engine
// works on one beat at a time and walks its tables in turn: the monitored set, the group
// records and, for a known group exec with a file, the allowlist. tables fill from entry 0
// upward and never shrink, so a fill count stands in for valid bits and no clearing pass
// follows reset. each stored entry visited is first read and then compared (one memory
// read port per table, read data registered). the learn and grace windows are 40 bit
// registers at byte addresses 0 and 8 and should be written only while no beat is in
// flight.
module exec_allowlist_learn_enforce (
	input  logic clk,
	input  logic arst_n,
	// input channel
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic [63:0] cgroup_id,
	input  logic has_file,
	input  logic [31:0] device_number,
	input  logic [63:0] inode_number,
	input  logic [63:0] now_time,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic deny,
	output logic monitored,
	output logic [1:0] mode_after,
	output logic newly_learned,
	output logic table_full,
	// configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	logic [eale_pkg::WIN_W-1:0] learn_q;
	logic [eale_pkg::WIN_W-1:0] grace_q;
	logic wr_en;
	logic q_valid;
	logic q_pop;
	eale_pkg::item_t q_item;
	eale_pkg::res_t res;

	// no wait states on the configuration port
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// register select is bit 3 of the byte address, anything else aliases onto it
	always_comb begin
		unique case (paddr[3])
			eale_pkg::REG_LEARN: prdata = {24'd0, learn_q};
			eale_pkg::REG_GRACE: prdata = {24'd0, grace_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q <= eale_pkg::WIN_RESET;
			grace_q <= eale_pkg::WIN_RESET;
		end else if (wr_en) begin
			if (paddr[3] == eale_pkg::REG_LEARN) begin
				learn_q <= pwdata[eale_pkg::WIN_W-1:0];
			end else begin
				grace_q <= pwdata[eale_pkg::WIN_W-1:0];
			end
		end
	end

	// front end: classify and queue
	eale_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.cgroup_id(cgroup_id),
		.has_file(has_file),
		.device_number(device_number),
		.inode_number(inode_number),
		.now_time(now_time),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	// back end: table walks, decision and result register
	eale_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.learn_window(learn_q),
		.grace_window(grace_q),
		.res_valid(out_valid),
		.res(res),
		.res_ready(out_ready)
	);

	assign deny = res.deny;
	assign monitored = res.monitored;
	assign mode_after = res.mode_after;
	assign newly_learned = res.newly_learned;
	assign table_full = res.table_full;

endmodule
